FILE: sv/zcdp_pkg.sv
// Shared types and constants of the ZIP central directory parser.
package zcdp_pkg;

  // Central directory file header signature, as read little-endian.
  localparam logic [31:0] CdSignature = 32'h0201_4B50;

  // Byte positions inside the 46-byte central directory header.
  localparam logic [5:0] PosSigEnd      = 6'd4;
  localparam logic [5:0] PosMethodLo    = 6'd10;
  localparam logic [5:0] PosMethodHi    = 6'd11;
  localparam logic [5:0] PosPackedLo    = 6'd20;
  localparam logic [5:0] PosPlainLo     = 6'd24;
  localparam logic [5:0] PosNameLenLo   = 6'd28;
  localparam logic [5:0] PosNameLenHi   = 6'd29;
  localparam logic [5:0] PosExtraLenLo  = 6'd30;
  localparam logic [5:0] PosExtraLenHi  = 6'd31;
  localparam logic [5:0] PosCommentLo   = 6'd32;
  localparam logic [5:0] PosCommentHi   = 6'd33;
  localparam logic [5:0] PosOffsetLo    = 6'd42;
  localparam logic [5:0] PosHeaderLast  = 6'd45;

  localparam logic [15:0] TallyMax = 16'hFFFF;

  // Parser phase, one-hot.
  typedef enum logic [3:0] {
    PhHeader = 4'b0001,
    PhName   = 4'b0010,
    PhSkip   = 4'b0100,
    PhStop   = 4'b1000
  } phase_e;

  // Kind of a result request.
  typedef enum logic [1:0] {
    KindNameByte = 2'd0,
    KindEntry    = 2'd1,
    KindReport   = 2'd2
  } kind_e;

  // Reason reported when the directory ends.
  typedef enum logic [1:0] {
    StopOutOfBytes = 2'd0,
    StopBadSig     = 2'd1,
    StopNameCut    = 2'd2
  } stop_e;

  // Pending result requests of one input byte; output order is name, entry, report.
  typedef struct packed {
    logic report;
    logic entry;
    logic name;
  } pending_t;

endpackage

FILE: sv/zip_central_directory_parser.sv
// ZIP central directory parser: byte-wide parsing core with a result bundle register.
//
// The input channel carries one directory byte per request (data_byte_i) and
// final_byte_i on the last byte of the directory buffer. The output channel
// carries result requests: a name byte, an entry record after the last name
// byte (or on the last header byte when the name is empty), and an end of
// directory report on the final byte. Fields that do not belong to a
// request's kind are zero, and run_end_o marks the last request that a byte
// caused.
//
// Each accepted byte is parsed in the cycle it is taken; the up to three
// requests it causes are captured in a bundle register and show on the
// output from the next cycle, one per cycle while the receiver does not stall.
// A byte is taken while the bundle still holds its last request being
// delivered, so bytes that cause at most one request flow at one per cycle
// when unstalled; a byte with two or three requests holds input until all but
// its last are out. Stalls and the output request count are the only limits.
//
// Reset clears the parser to the header phase with no pending requests.
// While the receiver stalls, the current request holds and input stalls as
// soon as the bundle cannot be emptied in that cycle.
module zip_central_directory_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        final_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  name_char_o,
  output logic [15:0] method_o,
  output logic [31:0] packed_size_o,
  output logic [31:0] plain_size_o,
  output logic [31:0] header_offset_o,
  output logic [15:0] name_length_o,
  output logic [15:0] entries_found_o,
  output logic [1:0]  stop_status_o,
  output logic        run_end_o
);

  // Parser state.
  zcdp_pkg::phase_e phase_q, phase_d;
  logic [5:0]  pos_q, pos_d;
  logic [31:0] sig_q, sig_d;
  logic [15:0] method_q, method_d;
  logic [31:0] packed_q, packed_d;
  logic [31:0] plain_q, plain_d;
  logic [31:0] offset_q, offset_d;
  logic [15:0] fname_len_q, fname_len_d;
  logic [15:0] xtra_len_q, xtra_len_d;
  logic [15:0] note_len_q, note_len_d;
  logic [16:0] left_q, left_d;
  logic [15:0] tally_q, tally_d;
  logic [1:0]  reason_q, reason_d;

  // Result bundle of the most recent byte.
  zcdp_pkg::pending_t pend_q, pend_d, pend_after, pend_new;
  logic [7:0]  b_char_q, b_char_d;
  logic [15:0] b_method_q, b_method_d;
  logic [31:0] b_packed_q, b_packed_d;
  logic [31:0] b_plain_q, b_plain_d;
  logic [31:0] b_offset_q, b_offset_d;
  logic [15:0] b_fname_len_q, b_fname_len_d;
  logic [15:0] b_tally_q, b_tally_d;
  logic [1:0]  b_status_q, b_status_d;

  logic in_fire, out_fire;
  logic [2:0] pend_bits;
  logic emit;
  logic [1:0] off_lane;

  assign pend_bits = pend_q;
  assign out_valid_o = (pend_bits != 3'b000);
  assign out_fire = out_valid_o && !out_stall_i;

  // Offset 42 has low bits 2'b10, so the lane is the low bits minus two.
  assign off_lane = pos_q[1:0] - 2'd2;

  // Drop the request being delivered this cycle, lowest pending first.
  always_comb begin
    pend_after = pend_q;
    if (out_fire) begin
      if (pend_q.name) begin
        pend_after.name = 1'b0;
      end else if (pend_q.entry) begin
        pend_after.entry = 1'b0;
      end else begin
        pend_after.report = 1'b0;
      end
    end
  end

  assign in_stall_o = (pend_after != 3'b000);
  assign in_fire = in_valid_i && !in_stall_o;

  // Parse one byte: field capture, counters, and the requests it causes.
  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    sig_d       = sig_q;
    method_d    = method_q;
    packed_d    = packed_q;
    plain_d     = plain_q;
    offset_d    = offset_q;
    fname_len_d = fname_len_q;
    xtra_len_d  = xtra_len_q;
    note_len_d  = note_len_q;
    left_d      = left_q;
    tally_d     = tally_q;
    reason_d    = reason_q;
    pend_new    = '0;
    emit        = 1'b0;
    b_char_d    = data_byte_i;
    b_status_d  = zcdp_pkg::StopOutOfBytes;

    unique case (phase_q)
      zcdp_pkg::PhHeader: begin
        if (pos_q < zcdp_pkg::PosSigEnd) begin
          sig_d = {data_byte_i, sig_q[31:8]};
        end
        if (pos_q == zcdp_pkg::PosMethodLo) method_d[7:0]  = data_byte_i;
        if (pos_q == zcdp_pkg::PosMethodHi) method_d[15:8] = data_byte_i;
        // Four-byte fields take the byte in the lane given by the low position bits.
        if (pos_q >= zcdp_pkg::PosPackedLo && pos_q < zcdp_pkg::PosPlainLo) begin
          packed_d[8*(pos_q[1:0]) +: 8] = data_byte_i;
        end
        if (pos_q >= zcdp_pkg::PosPlainLo && pos_q < zcdp_pkg::PosNameLenLo) begin
          plain_d[8*(pos_q[1:0]) +: 8] = data_byte_i;
        end
        if (pos_q == zcdp_pkg::PosNameLenLo)  fname_len_d[7:0]  = data_byte_i;
        if (pos_q == zcdp_pkg::PosNameLenHi)  fname_len_d[15:8] = data_byte_i;
        if (pos_q == zcdp_pkg::PosExtraLenLo) xtra_len_d[7:0]   = data_byte_i;
        if (pos_q == zcdp_pkg::PosExtraLenHi) xtra_len_d[15:8]  = data_byte_i;
        if (pos_q == zcdp_pkg::PosCommentLo)  note_len_d[7:0]   = data_byte_i;
        if (pos_q == zcdp_pkg::PosCommentHi)  note_len_d[15:8]  = data_byte_i;
        if (pos_q >= zcdp_pkg::PosOffsetLo) begin
          offset_d[8*off_lane +: 8] = data_byte_i;
        end

        if (pos_q >= zcdp_pkg::PosHeaderLast) begin
          pos_d = '0;
          if (sig_d != zcdp_pkg::CdSignature) begin
            phase_d  = zcdp_pkg::PhStop;
            reason_d = zcdp_pkg::StopBadSig;
          end else if (fname_len_d == 16'd0) begin
            emit = 1'b1;
          end else begin
            left_d  = {1'b0, fname_len_d};
            phase_d = zcdp_pkg::PhName;
          end
        end else begin
          pos_d = pos_q + 6'd1;
        end
      end
      zcdp_pkg::PhName: begin
        pend_new.name = 1'b1;
        left_d = left_q - 17'd1;
        if (left_d == 17'd0) begin
          emit = 1'b1;
        end
      end
      zcdp_pkg::PhSkip: begin
        left_d = left_q - 17'd1;
        if (left_d == 17'd0) begin
          phase_d = zcdp_pkg::PhHeader;
        end
      end
      zcdp_pkg::PhStop: begin
      end
      default: begin
      end
    endcase

    // Entry record, then skip the extra and comment bytes.
    if (emit) begin
      pend_new.entry = 1'b1;
      if (tally_q != zcdp_pkg::TallyMax) begin
        tally_d = tally_q + 16'd1;
      end
      left_d  = {1'b0, xtra_len_d} + {1'b0, note_len_d};
      phase_d = (left_d == 17'd0) ? zcdp_pkg::PhHeader : zcdp_pkg::PhSkip;
    end

    b_method_d    = method_d;
    b_packed_d    = packed_d;
    b_plain_d     = plain_d;
    b_offset_d    = offset_d;
    b_fname_len_d = fname_len_d;
    b_tally_d     = tally_d;

    // End of the directory: report, then back to the reset state.
    if (final_byte_i) begin
      pend_new.report = 1'b1;
      if (phase_d == zcdp_pkg::PhStop) begin
        b_status_d = reason_d;
      end else if (phase_d == zcdp_pkg::PhName) begin
        b_status_d = zcdp_pkg::StopNameCut;
      end else begin
        b_status_d = zcdp_pkg::StopOutOfBytes;
      end
      phase_d     = zcdp_pkg::PhHeader;
      pos_d       = '0;
      sig_d       = '0;
      method_d    = '0;
      packed_d    = '0;
      plain_d     = '0;
      offset_d    = '0;
      fname_len_d = '0;
      xtra_len_d  = '0;
      note_len_d  = '0;
      left_d      = '0;
      tally_d     = '0;
      reason_d    = '0;
    end

    pend_d = in_fire ? pend_new : pend_after;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= zcdp_pkg::PhHeader;
      pos_q       <= '0;
      sig_q       <= '0;
      method_q    <= '0;
      packed_q    <= '0;
      plain_q     <= '0;
      offset_q    <= '0;
      fname_len_q <= '0;
      xtra_len_q  <= '0;
      note_len_q  <= '0;
      left_q      <= '0;
      tally_q     <= '0;
      reason_q    <= '0;
      pend_q      <= '0;
    end else begin
      pend_q <= pend_d;
      if (in_fire) begin
        phase_q     <= phase_d;
        pos_q       <= pos_d;
        sig_q       <= sig_d;
        method_q    <= method_d;
        packed_q    <= packed_d;
        plain_q     <= plain_d;
        offset_q    <= offset_d;
        fname_len_q <= fname_len_d;
        xtra_len_q  <= xtra_len_d;
        note_len_q  <= note_len_d;
        left_q      <= left_d;
        tally_q     <= tally_d;
        reason_q    <= reason_d;
      end
    end
  end

  // Bundle payload needs no reset; it is only read while a request is pending.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      b_char_q      <= b_char_d;
      b_method_q    <= b_method_d;
      b_packed_q    <= b_packed_d;
      b_plain_q     <= b_plain_d;
      b_offset_q    <= b_offset_d;
      b_fname_len_q <= b_fname_len_d;
      b_tally_q     <= b_tally_d;
      b_status_q    <= b_status_d;
    end
  end

  // Present the lowest pending request; other kinds' fields read as zero.
  always_comb begin
    kind_o          = zcdp_pkg::KindReport;
    name_char_o     = '0;
    method_o        = '0;
    packed_size_o   = '0;
    plain_size_o    = '0;
    header_offset_o = '0;
    name_length_o   = '0;
    entries_found_o = '0;
    stop_status_o   = '0;
    if (pend_q.name) begin
      kind_o      = zcdp_pkg::KindNameByte;
      name_char_o = b_char_q;
    end else if (pend_q.entry) begin
      kind_o          = zcdp_pkg::KindEntry;
      method_o        = b_method_q;
      packed_size_o   = b_packed_q;
      plain_size_o    = b_plain_q;
      header_offset_o = b_offset_q;
      name_length_o   = b_fname_len_q;
    end else begin
      entries_found_o = b_tally_q;
      stop_status_o   = b_status_q;
    end
  end

  // The last request of a byte is the one with no other request behind it.
  assign run_end_o = $onehot(pend_bits);

endmodule
